@@ hdl/tpt_pkg.sv @@
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared widths, parameter defaults and controller/datapath interface types
// for the TLB and page-table address translator.
// ----------------------------------------------------------------------------
package tpt_pkg;

    localparam int ADDR_W  = 16;
    localparam int FRAME_W = 8;
    localparam int FREE_W  = 9;
    localparam int COUNT_W = 32;

    localparam int TLB_ENTRIES_DEF = 16;
    localparam int PAGE_COUNT_DEF  = 256;
    localparam int PAGE_BYTES_DEF  = 256;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic commit;
    } tpt_cmd_t;

    typedef struct packed {
        logic clear_last;
    } tpt_status_t;

endpackage

@@ hdl/tpt_ctrl.sv @@
// ----------------------------------------------------------------------------
// tpt_ctrl
// Sequencer: page-table clearing pass, input acceptance, commit and the
// result valid flag.
// ----------------------------------------------------------------------------
module tpt_ctrl
    import tpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        addr_valid,
    output logic        addr_stall,
    output logic        xlat_valid,
    input  logic        xlat_stall,
    input  tpt_status_t status,
    output tpt_cmd_t    cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg & xlat_stall;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (addr_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold while a stalled result still occupies the output
                if (!out_valid_reg || !xlat_stall)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign addr_stall = (state_reg != ST_IDLE);
    assign xlat_valid = out_valid_reg;

endmodule

@@ hdl/tpt_tlb.sv @@
// ----------------------------------------------------------------------------
// tpt_tlb
// Fully associative TLB kept in LRU order: entry 0 is the oldest. Parallel
// lookup over the valid entries; an update removes the hit (or the oldest
// entry when full) and appends the page at the newest position.
// ----------------------------------------------------------------------------
module tpt_tlb
    import tpt_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
    parameter int PAGE_W      = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [PAGE_W-1:0]  lookup_page,
    output logic               hit,
    output logic [FRAME_W-1:0] hit_frame,
    input  logic               upd,
    input  logic [FRAME_W-1:0] upd_frame
);

    localparam int FILL_W = $clog2(TLB_ENTRIES + 1);
    localparam logic [FILL_W-1:0] FULL = FILL_W'(TLB_ENTRIES);

    logic [PAGE_W-1:0]  pages_reg  [TLB_ENTRIES];
    logic [FRAME_W-1:0] frames_reg [TLB_ENTRIES];
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [TLB_ENTRIES-1:0] match;
    logic [FILL_W-1:0]  found;
    logic               full;
    logic [FILL_W-1:0]  rm_pos;
    logic [FILL_W-1:0]  new_pos;

    always_comb
    begin
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            match[i] = (FILL_W'(i) < fill_reg) && (pages_reg[i] == lookup_page);
        end
    end

    // lowest matching index wins
    always_comb
    begin
        hit       = 1'b0;
        found     = '0;
        hit_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit       = 1'b1;
                found     = FILL_W'(i);
                hit_frame = frames_reg[i];
            end
        end
    end

    assign full    = (fill_reg == FULL);
    assign rm_pos  = hit ? found : (full ? '0 : fill_reg);
    assign new_pos = (hit || full) ? (fill_reg - 1'b1) : fill_reg;

    always_comb
    begin
        fill_next = fill_reg;
        if (upd && !hit && !full)
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    for (genvar g = 0; g < TLB_ENTRIES; g++)
    begin : g_entry
        if (g < TLB_ENTRIES - 1)
        begin : g_shift
            always_ff @(posedge clk)
            begin
                if (upd)
                begin
                    if (FILL_W'(g) == new_pos)
                    begin
                        pages_reg[g]  <= lookup_page;
                        frames_reg[g] <= upd_frame;
                    end
                    else if (FILL_W'(g) >= rm_pos && FILL_W'(g) < new_pos)
                    begin
                        pages_reg[g]  <= pages_reg[g+1];
                        frames_reg[g] <= frames_reg[g+1];
                    end
                end
            end
        end
        else
        begin : g_top
            always_ff @(posedge clk)
            begin
                if (upd && FILL_W'(g) == new_pos)
                begin
                    pages_reg[g]  <= lookup_page;
                    frames_reg[g] <= upd_frame;
                end
            end
        end
    end

endmodule

@@ hdl/tpt_datapath.sv @@
// ----------------------------------------------------------------------------
// tpt_datapath
// Address split, page-table memory with registered read, TLB, frame
// allocation, saturating counters and result registers.
// ----------------------------------------------------------------------------
module tpt_datapath
    import tpt_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
    parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  tpt_cmd_t           cmd,
    output tpt_status_t        status,
    input  logic [ADDR_W-1:0]  logical_address,
    output logic [ADDR_W-1:0]  physical_address,
    output logic [FRAME_W-1:0] frame_number,
    output logic               tlb_hit,
    output logic               page_fault,
    output logic [COUNT_W-1:0] hits_total,
    output logic [COUNT_W-1:0] faults_total
);

    localparam int PAGE_W   = $clog2(PAGE_COUNT);
    localparam int OFFSET_W = $clog2(PAGE_BYTES);
    localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PAGE_COUNT - 1);

    logic [FRAME_W:0]     pt_mem [PAGE_COUNT];
    logic [FRAME_W:0]     rd_data_reg;
    logic [PAGE_W-1:0]    clear_idx_reg;
    logic [PAGE_W-1:0]    page_reg;
    logic [OFFSET_W-1:0]  offset_reg;
    logic [ADDR_W-1:0]    addr_shift;
    logic [PAGE_W-1:0]    in_page;
    logic [FREE_W-1:0]    next_free_reg;
    logic [COUNT_W-1:0]   hit_cnt_reg;
    logic [COUNT_W-1:0]   fault_cnt_reg;
    logic [ADDR_W-1:0]    phys_reg;
    logic [FRAME_W-1:0]   frame_reg;
    logic                 hit_reg;
    logic                 fault_reg;
    logic                 tlb_hit_now;
    logic [FRAME_W-1:0]   tlb_frame;
    logic                 present;
    logic                 fault;
    logic [FRAME_W-1:0]   frame;

    assign addr_shift = logical_address >> OFFSET_W;
    assign in_page    = addr_shift[PAGE_W-1:0];

    assign status.clear_last = (clear_idx_reg == LAST_PAGE);

    tpt_tlb #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .PAGE_W      (PAGE_W)
    ) u_tlb (
        .clk         (clk),
        .rst_n       (rst_n),
        .lookup_page (page_reg),
        .hit         (tlb_hit_now),
        .hit_frame   (tlb_frame),
        .upd         (cmd.commit),
        .upd_frame   (frame)
    );

    assign present = rd_data_reg[FRAME_W];
    assign fault   = !tlb_hit_now && !present;

    always_comb
    begin
        priority if (tlb_hit_now)
        begin
            frame = tlb_frame;
        end
        else if (present)
        begin
            frame = rd_data_reg[FRAME_W-1:0];
        end
        else
        begin
            frame = next_free_reg[FRAME_W-1:0];
        end
    end

    // page table: one write port (clear or allocate), one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            pt_mem[clear_idx_reg] <= '0;
        end
        else if (cmd.commit && fault)
        begin
            pt_mem[page_reg] <= {1'b1, frame};
        end
        if (cmd.accept)
        begin
            rd_data_reg <= pt_mem[in_page];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            page_reg   <= in_page;
            offset_reg <= logical_address[OFFSET_W-1:0];
        end
        if (cmd.commit)
        begin
            phys_reg  <= (ADDR_W'(frame) << OFFSET_W) | ADDR_W'(offset_reg);
            frame_reg <= frame;
            hit_reg   <= tlb_hit_now;
            fault_reg <= fault;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_idx_reg <= '0;
            next_free_reg <= '0;
            hit_cnt_reg   <= '0;
            fault_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clear_idx_reg <= clear_idx_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                if (tlb_hit_now && hit_cnt_reg != '1)
                begin
                    hit_cnt_reg <= hit_cnt_reg + 1'b1;
                end
                if (fault)
                begin
                    next_free_reg <= next_free_reg + 1'b1;
                    if (fault_cnt_reg != '1)
                    begin
                        fault_cnt_reg <= fault_cnt_reg + 1'b1;
                    end
                end
            end
        end
    end

    assign physical_address = phys_reg;
    assign frame_number     = frame_reg;
    assign tlb_hit          = hit_reg;
    assign page_fault       = fault_reg;
    assign hits_total       = hit_cnt_reg;
    assign faults_total     = fault_cnt_reg;

endmodule

@@ hdl/tlb_page_table_translator_top.sv @@
// ----------------------------------------------------------------------------
// tlb_page_table_translator_top
// Logical-to-physical address translation through an LRU TLB backed by a
// page table with in-order frame allocation on page faults.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (addr_valid / addr_stall / logical_address): one transaction
//   carries a logical address; the page sits above the offset.
//   Output channel (xlat_valid / xlat_stall / result fields): one transaction
//   per input transaction, in order, with the physical address, the frame,
//   the hit and fault flags and saturating hit and fault totals.
//   Steps: one transaction is in flight at a time. The accept edge starts
//   the page-table memory read; the commit edge takes the registered read
//   data, resolves hit / present / fault, writes the page table on a fault,
//   updates the TLB order and loads the result register, and xlat_valid
//   rises after it. Commit waits while a stalled result holds the output.
//   A new address is accepted while an earlier result still waits on the
//   output; if the output stays stalled, the second transaction holds in the
//   commit step and addr_stall stays high until the output drains.
//   Reset: clears the TLB fill count, frame allocator and counters, then
//   runs a clearing pass over all PAGE_COUNT page-table entries (256 by
//   default), with addr_stall high throughout.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_top
    import tpt_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
    parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               addr_valid,
    output logic               addr_stall,
    input  logic [ADDR_W-1:0]  logical_address,
    output logic               xlat_valid,
    input  logic               xlat_stall,
    output logic [ADDR_W-1:0]  physical_address,
    output logic [FRAME_W-1:0] frame_number,
    output logic               tlb_hit,
    output logic               page_fault,
    output logic [COUNT_W-1:0] hits_total,
    output logic [COUNT_W-1:0] faults_total
);

    tpt_cmd_t    cmd;
    tpt_status_t status;

    // sequencer: clearing pass, accept, commit, result valid
    tpt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .addr_valid (addr_valid),
        .addr_stall (addr_stall),
        .xlat_valid (xlat_valid),
        .xlat_stall (xlat_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // translation datapath: page table, TLB, allocator, counters, results
    tpt_datapath #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .PAGE_COUNT  (PAGE_COUNT),
        .PAGE_BYTES  (PAGE_BYTES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .logical_address  (logical_address),
        .physical_address (physical_address),
        .frame_number     (frame_number),
        .tlb_hit          (tlb_hit),
        .page_fault       (page_fault),
        .hits_total       (hits_total),
        .faults_total     (faults_total)
    );

endmodule

@@ hdl/tpt_checker.sv @@
// ----------------------------------------------------------------------------
// tpt_checker
// Port-level checks for the translator, bound to the top level.
// ----------------------------------------------------------------------------
module tpt_checker
    import tpt_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               addr_valid,
    input logic               addr_stall,
    input logic [ADDR_W-1:0]  logical_address,
    input logic               xlat_valid,
    input logic               xlat_stall,
    input logic [ADDR_W-1:0]  physical_address,
    input logic [FRAME_W-1:0] frame_number,
    input logic               tlb_hit,
    input logic               page_fault,
    input logic [COUNT_W-1:0] hits_total,
    input logic [COUNT_W-1:0] faults_total
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        xlat_valid && xlat_stall |=> xlat_valid)
        else $error("result dropped while stalled");

    // one transaction in flight: stall right after accept, then a result
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        addr_valid && !addr_stall |=> addr_stall ##1 xlat_valid)
        else $error("accepted transaction not followed by a result");

    // a TLB hit is never also a fault
    a_hit_not_fault: assert property (@(posedge clk) disable iff (!rst_n)
        xlat_valid |-> !(tlb_hit && page_fault))
        else $error("hit and fault flagged together");

    // the fault total moves only with a new faulting result
    a_fault_count: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(faults_total) |-> xlat_valid && page_fault)
        else $error("fault total changed without a fault");

    // the hit total moves only with a new hitting result
    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(hits_total) |-> xlat_valid && tlb_hit)
        else $error("hit total changed without a hit");

endmodule

bind tlb_page_table_translator_top tpt_checker u_checker (.*);

@@ verif/tb_tlb_page_table_translator_top.sv @@
// ----------------------------------------------------------------------------
// tb_tlb_page_table_translator_top
// Self-checking bench for the TLB / page-table address translator. A short
// directed sequence covers the address extremes, TLB hits, page faults,
// LRU eviction and a page-table hit after eviction. Random traffic follows,
// mixing hot pages, recently used pages, a mid-size working set and fully
// random addresses. A behavioral translator predicts every result, and each
// output transaction is compared field by field against the oldest
// prediction. Sender idling and receiver stalling change from phase to phase.
// ----------------------------------------------------------------------------
module tb_tlb_page_table_translator_top;
    import tpt_pkg::*;

    localparam int TLB_DEPTH        = TLB_ENTRIES_DEF;
    localparam int TABLE_DEPTH      = PAGE_COUNT_DEF;
    localparam int RANDOM_PER_PHASE = 482;
    localparam int HOLD_CYCLES      = 60;
    localparam int DRAIN_CYCLES     = 8;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int MAX_PRINTED      = 40;

    // Per-phase idle and stall odds, in percent; phase 0 is the rightmost byte.
    localparam bit [3:0][7:0] IDLE_PCT  = {8'd33, 8'd0, 8'd83, 8'd0};
    localparam bit [3:0][7:0] STALL_PCT = {8'd33, 8'd83, 8'd0, 8'd0};

    typedef struct {
        logic [ADDR_W-1:0]  phys;
        logic [FRAME_W-1:0] frame;
        logic               hit;
        logic               fault;
        logic [COUNT_W-1:0] hits;
        logic [COUNT_W-1:0] faults;
    } xlat_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               addr_valid = 1'b0;
    logic               addr_stall;
    logic [ADDR_W-1:0]  logical_address = '0;
    logic               xlat_valid;
    logic               xlat_stall = 1'b0;
    logic [ADDR_W-1:0]  physical_address;
    logic [FRAME_W-1:0] frame_number;
    logic               tlb_hit;
    logic               page_fault;
    logic [COUNT_W-1:0] hits_total;
    logic [COUNT_W-1:0] faults_total;

    // Stimulus and scoreboard storage
    logic [ADDR_W-1:0] addr_queue[$];
    xlat_t             expected_xlat[$];
    xlat_t             want_xlat;
    logic [7:0]        recent_pages[$];
    logic [7:0]        hot_base = '0;

    // Knobs, changed only on the falling edge by the sequencing and hold-off blocks
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_go = 1'b0;
    bit          long_hold = 1'b0;

    int mismatch_count = 0;
    int addrs_sent = 0;
    int results_seen = 0;
    int hit_seen = 0;
    int fault_seen = 0;
    int table_seen = 0;
    int cycle_count = 0;

    // Predictor state: LRU-ordered TLB (index 0 is oldest), page table,
    // in-order frame allocator and saturating totals.
    logic [7:0]         lru_page[TLB_DEPTH];
    logic [7:0]         lru_frame[TLB_DEPTH];
    int                 lru_fill = 0;
    logic [7:0]         pt_frame[TABLE_DEPTH];
    bit                 pt_present[TABLE_DEPTH];
    logic [FREE_W-1:0]  free_frame = '0;
    logic [COUNT_W-1:0] hit_count = '0;
    logic [COUNT_W-1:0] fault_count = '0;

    tlb_page_table_translator_top u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .addr_valid       (addr_valid),
        .addr_stall       (addr_stall),
        .logical_address  (logical_address),
        .xlat_valid       (xlat_valid),
        .xlat_stall       (xlat_stall),
        .physical_address (physical_address),
        .frame_number     (frame_number),
        .tlb_hit          (tlb_hit),
        .page_fault       (page_fault),
        .hits_total       (hits_total),
        .faults_total     (faults_total)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Translate one address and advance the predictor state.
    function automatic xlat_t translate_address(input logic [ADDR_W-1:0] la);
        xlat_t      r;
        logic [7:0] pg;
        int         slot;
        pg = la[15:8];
        slot = -1;
        r.hit = 1'b0;
        r.fault = 1'b0;
        // Search only the filled slots so an empty TLB never hits.
        for (int k = 0; k < lru_fill; k++)
            if (slot < 0 && lru_page[k] == pg)
                slot = k;
        if (slot >= 0)
        begin
            r.hit = 1'b1;
            r.frame = lru_frame[slot];
            if (hit_count != '1)
                hit_count++;
            // Pull the entry out; it is appended again as newest below.
            for (int k = slot; k < lru_fill - 1; k++)
            begin
                lru_page[k] = lru_page[k + 1];
                lru_frame[k] = lru_frame[k + 1];
            end
            lru_fill--;
        end
        else if (pt_present[pg])
            r.frame = pt_frame[pg];
        else
        begin
            r.fault = 1'b1;
            r.frame = free_frame[7:0];
            free_frame = free_frame + 1'b1;
            pt_frame[pg] = r.frame;
            pt_present[pg] = 1'b1;
            if (fault_count != '1)
                fault_count++;
        end
        // Drop the oldest entry when the TLB is full.
        if (lru_fill == TLB_DEPTH)
        begin
            for (int k = 0; k < TLB_DEPTH - 1; k++)
            begin
                lru_page[k] = lru_page[k + 1];
                lru_frame[k] = lru_frame[k + 1];
            end
            lru_fill--;
        end
        lru_page[lru_fill] = pg;
        lru_frame[lru_fill] = r.frame;
        lru_fill++;
        r.phys = {r.frame, la[7:0]};
        r.hits = hit_count;
        r.faults = fault_count;
        return r;
    endfunction

    // Pick a random address, biased toward pages that produce TLB hits and
    // page-table hits after eviction rather than only cold faults.
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [7:0] pg;
        int         roll;
        roll = $urandom_range(99);
        if (roll < 40)
            pg = hot_base + 8'($urandom_range(7));
        else if (roll < 65 && recent_pages.size() != 0)
            pg = recent_pages[$urandom_range(recent_pages.size() - 1)];
        else if (roll < 85)
            pg = 8'($urandom_range(63));
        else
            pg = 8'($urandom);
        recent_pages.push_back(pg);
        if (recent_pages.size() > 40)
            void'(recent_pages.pop_front());
        return {pg, 8'($urandom)};
    endfunction

    task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] got,
                                   input logic [COUNT_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch: result %0d %s got 0x%0h expected 0x%0h",
                     results_seen, what, got, want);
    endtask

    task automatic compare_field(input string what, input logic [COUNT_W-1:0] got,
                                 input logic [COUNT_W-1:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Hold the sender until every queued address is accepted and every
    // predicted result has come back.
    task automatic wait_for_drain();
        while (addr_queue.size() != 0 || addr_valid || expected_xlat.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: on an accepted transaction, predict its result; then offer
    // the next address unless this cycle idles. A stalled transaction
    // keeps its payload untouched.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_valid <= 1'b0;
            logical_address <= '0;
        end
        else
        begin
            if (addr_valid && !addr_stall)
            begin
                expected_xlat.push_back(translate_address(logical_address));
                addrs_sent++;
            end
            if (!addr_valid || !addr_stall)
            begin
                if (addr_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    addr_valid <= 1'b1;
                    logical_address <= addr_queue.pop_front();
                end
                else
                    addr_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted result against the oldest prediction,
    // then pick the stall for the next cycle. The long hold-off overrides
    // the random stall.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            xlat_stall <= 1'b0;
        else
        begin
            if (xlat_valid && !xlat_stall)
            begin
                if (expected_xlat.size() == 0)
                    report_mismatch("unexpected transaction, physical_address",
                                    COUNT_W'(physical_address), '0);
                else
                begin
                    want_xlat = expected_xlat.pop_front();
                    compare_field("physical_address", COUNT_W'(physical_address),
                                  COUNT_W'(want_xlat.phys));
                    compare_field("frame_number", COUNT_W'(frame_number),
                                  COUNT_W'(want_xlat.frame));
                    compare_field("tlb_hit", COUNT_W'(tlb_hit), COUNT_W'(want_xlat.hit));
                    compare_field("page_fault", COUNT_W'(page_fault),
                                  COUNT_W'(want_xlat.fault));
                    compare_field("hits_total", hits_total, want_xlat.hits);
                    compare_field("faults_total", faults_total, want_xlat.faults);
                    if (want_xlat.hit)
                        hit_seen++;
                    else if (want_xlat.fault)
                        fault_seen++;
                    else
                        table_seen++;
                end
                results_seen++;
            end
            xlat_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Long output hold-off, counted here so the sender keeps offering
    // addresses and the block backs up into its input.
    initial
    begin
        wait (hold_go);
        @(negedge clk);
        long_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
    end

    // Watchdog: covers the reset clearing pass and the slowest phases.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_xlat.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing: reset, directed addresses, then four random phases with
    // different idle and stall odds. Every knob changes on the falling
    // edge so the clocked blocks never race with it.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Page 0 faults into frame 0, then hits at the top offset.
        addr_queue.push_back(16'h0000);
        addr_queue.push_back(16'h00FF);
        // Top page faults, hits at offset 0; page 0 hits again.
        addr_queue.push_back(16'hFFFF);
        addr_queue.push_back(16'hFF00);
        addr_queue.push_back(16'h0000);
        // Sixteen new pages fill the TLB, and the last two evict the
        // top page and page 0 in LRU order.
        for (int p = 1; p <= 16; p++)
            addr_queue.push_back({8'(p), (p % 2 != 0) ? 8'h55 : 8'hAA});
        // Evicted but present: page-table hit with neither flag set.
        addr_queue.push_back(16'hFF80);
        addr_queue.push_back(16'h0001);
        // Opposite bit patterns across page and offset.
        addr_queue.push_back(16'h7FFF);
        addr_queue.push_back(16'h8000);
        wait_for_drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            @(negedge clk);
            send_idle_pct = IDLE_PCT[ph];
            recv_stall_pct = STALL_PCT[ph];
            // Start the long hold-off while the sender runs flat out.
            if (ph == 0)
                hold_go = 1'b1;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (n % 64 == 0)
                    hot_base = 8'($urandom);
                addr_queue.push_back(pick_address());
            end
            wait_for_drain();
        end

        // Let any stray late result show up before the verdict.
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Translated %0d addresses: %0d TLB hits, %0d page faults, %0d page-table hits",
                 addrs_sent, hit_seen, fault_seen, table_seen);
        $display("Covered 4 idle/stall phases and a %0d-cycle output hold-off, %0d mismatches",
                 HOLD_CYCLES, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
